>>> rtl/bsbe_pkg.sv
`timescale 1ns / 1ps
package bsbe_pkg;

    localparam int MAX_KNOTS_DEF = 64;
    localparam int MAX_ORDER_DEF = 4;
    localparam int FRAC_BITS_DEF = 16;

    localparam int KNOT_W = 32;
    localparam int IDX_W  = 6;
    localparam int ORD_W  = 3;
    localparam int NCP_W  = 6;
    localparam int CFG_W  = 6;

    localparam logic [ORD_W-1:0] ORDER_RST = 3'd4;
    localparam logic [NCP_W-1:0] NCPT_RST  = 6'd4;

    typedef enum logic [0:0] {
        CFG_ORDER = 1'b0,
        CFG_NCPT  = 1'b1
    } t_cfg_idx;

    typedef enum logic [0:0] {
        KIND_LOAD = 1'b0,
        KIND_EVAL = 1'b1
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BINIT,
        S_RD_LO,
        S_RD_HI,
        S_RD_WAIT,
        S_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_NEXT,
        S_WR_B,
        S_OUT_RD,
        S_OUT_LD,
        S_ERR
    } t_state;

endpackage

>>> rtl/bsbe_in_if.sv
`timescale 1ns / 1ps
interface bsbe_in_if;
    import bsbe_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic [IDX_W-1:0]         knot_index;
    logic signed [KNOT_W-1:0] knot_value;
    logic signed [KNOT_W-1:0] param_t;
    logic [IDX_W-1:0]         span;

    modport source (output valid, kind, knot_index, knot_value, param_t, span, input ready);
    modport sink   (input valid, kind, knot_index, knot_value, param_t, span, output ready);
endinterface

>>> rtl/bsbe_out_if.sv
`timescale 1ns / 1ps
interface bsbe_out_if #(
    parameter int FRAC_BITS = bsbe_pkg::FRAC_BITS_DEF
);
    import bsbe_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [FRAC_BITS:0]   basis_value;
    logic [IDX_W-1:0]     basis_index;
    logic                 last;
    logic                 status;

    modport source (output valid, basis_value, basis_index, last, status, input ready);
    modport sink   (input valid, basis_value, basis_index, last, status, output ready);
endinterface

>>> rtl/bspline_basis_eval.sv
`timescale 1ns / 1ps
// a load item writes one knot; an evaluation of order k runs k*(k-1) terms, each with
// a division only when the knot difference is positive, plus one write-back per
// basis entry, before its results are emitted
// the shared restoring divider computes one quotient bit a cycle while busy
// one item at a time; results are emitted one by one, and a new item is taken while the
// last result waits in the output register
// reset (synchronous, active low) sets order 4 and 4 control points; knots stay undefined
module bspline_basis_eval
    import bsbe_pkg::*;
#(
    parameter int MAX_KNOTS = MAX_KNOTS_DEF,
    parameter int MAX_ORDER = MAX_ORDER_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    bsbe_in_if.sink          i_in,
    bsbe_out_if.source       o_out
);
    localparam int AW   = $clog2(MAX_KNOTS);
    localparam int KW   = $clog2(MAX_ORDER + 1);
    localparam int BW   = (MAX_ORDER > 2) ? $clog2(MAX_ORDER) : 1;
    localparam int VW   = FRAC_BITS + 1;
    localparam int PW   = FRAC_BITS + 35;
    localparam int SW   = PW + 1;
    localparam int NMAX = MAX_KNOTS - MAX_ORDER;
    localparam logic [VW-1:0] ONE = VW'(1) << FRAC_BITS;

    t_state r_state, n_state;

    logic [ORD_W-1:0]         r_order;
    logic [NCP_W-1:0]         r_ncpt;
    logic [KW-1:0]            r_k, r_d, r_r;
    logic [IDX_W-1:0]         r_s;
    logic signed [KNOT_W-1:0] r_t, r_lo;
    logic                     r_side;
    logic signed [SW-1:0]     r_acc;
    logic [VW-1:0]            r_b;
    logic signed [KNOT_W:0]   r_num, r_den;
    logic signed [PW-1:0]     r_prod;
    logic                     r_ov;
    logic [VW-1:0]            r_val;
    logic [IDX_W-1:0]         r_idx;
    logic                     r_last, r_stat;

    logic [KW-1:0]            w_k;
    logic [6:0]               w_n, w_i, w_lo, w_hi;
    logic                     w_bad, w_acc_in, w_can_load;
    logic                     w_kwe, w_bwe;
    logic [AW-1:0]            w_kraddr;
    logic [BW-1:0]            w_bwaddr, w_braddr;
    logic [VW-1:0]            w_bwdata, w_sat;
    logic signed [KNOT_W-1:0] w_kdata;
    logic [VW-1:0]            w_bdata;
    logic                     w_dstart, w_ddone;
    logic signed [PW-1:0]     w_quot;
    logic signed [KNOT_W:0]   w_hi_ext;

    always_comb begin
        if (r_order < ORD_W'(2)) w_k = KW'(2);
        else if (int'(r_order) > MAX_ORDER) w_k = KW'(MAX_ORDER);
        else w_k = KW'(r_order);
        if (r_ncpt < NCP_W'(2)) w_n = 7'd2;
        else if (int'(r_ncpt) > NMAX) w_n = 7'(NMAX);
        else w_n = 7'(r_ncpt);
    end

    assign w_bad = ((7'(i_in.span) + 7'd1) < 7'(w_k)) || ((7'(i_in.span) + 7'd1) > w_n);
    assign w_acc_in = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign w_can_load = !r_ov || o_out.ready;

    assign w_i  = 7'(r_s) - 7'(r_d) + 7'(r_r);
    assign w_lo = r_side ? (w_i + 7'd1) : w_i;
    assign w_hi = r_side ? (w_i + 7'(r_d) + 7'd1) : (w_i + 7'(r_d));
    assign w_kraddr = (r_state == S_RD_LO) ? AW'(w_lo) : AW'(w_hi);
    assign w_kwe = (r_state == S_IDLE) && w_acc_in && (i_in.kind == KIND_LOAD)
                   && (int'(i_in.knot_index) < MAX_KNOTS);

    assign w_braddr = r_side ? BW'(r_r) : BW'(r_r - KW'(1));
    assign w_bwe    = (r_state == S_BINIT) || (r_state == S_WR_B);
    assign w_bwaddr = (r_state == S_BINIT) ? '0 : BW'(r_r);
    assign w_bwdata = (r_state == S_BINIT) ? ONE : w_sat;

    always_comb begin
        if (r_acc < 0) w_sat = '0;
        else if (r_acc > SW'(ONE)) w_sat = ONE;
        else w_sat = r_acc[VW-1:0];
    end

    assign w_hi_ext = (KNOT_W+1)'(w_kdata);
    assign w_dstart = (r_state == S_DIV_GO) && (r_den > 0);

    bsbe_ram #(.WIDTH(KNOT_W), .DEPTH(MAX_KNOTS)) u_knots (
        .i_clk   (i_clk),
        .i_we    (w_kwe),
        .i_waddr (AW'(i_in.knot_index)),
        .i_wdata (i_in.knot_value),
        .i_raddr (w_kraddr),
        .o_rdata (w_kdata)
    );

    bsbe_ram #(.WIDTH(VW), .DEPTH(MAX_ORDER)) u_basis (
        .i_clk   (i_clk),
        .i_we    (w_bwe),
        .i_waddr (w_bwaddr),
        .i_wdata (w_bwdata),
        .i_raddr (w_braddr),
        .o_rdata (w_bdata)
    );

    bsbe_div #(.PW(PW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_dstart),
        .i_dividend (r_prod),
        .i_divisor  (r_den[KNOT_W-1:0]),
        .o_done     (w_ddone),
        .o_quotient (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_order <= ORDER_RST;
            r_ncpt  <= NCPT_RST;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_ORDER: r_order <= i_cfg_data[ORD_W-1:0];
                    CFG_NCPT:  r_ncpt  <= i_cfg_data[NCP_W-1:0];
                    default: ;
                endcase
            end
            if ((r_state == S_OUT_LD || r_state == S_ERR) && w_can_load) r_ov <= 1'b1;
            else if (o_out.ready) r_ov <= 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc_in && i_in.kind == KIND_EVAL) n_state = w_bad ? S_ERR : S_BINIT;
            end
            S_BINIT:    n_state = S_RD_LO;
            S_RD_LO:    n_state = S_RD_HI;
            S_RD_HI:    n_state = S_RD_WAIT;
            S_RD_WAIT:  n_state = S_MUL;
            S_MUL:      n_state = S_DIV_GO;
            S_DIV_GO:   n_state = (r_den > 0) ? S_DIV_WAIT : S_NEXT;
            S_DIV_WAIT: if (w_ddone) n_state = S_NEXT;
            S_NEXT: begin
                n_state = (!r_side && r_r < r_d) ? S_RD_LO : S_WR_B;
            end
            S_WR_B: begin
                n_state = (r_r == '0 && r_d == r_k - KW'(1)) ? S_OUT_RD : S_RD_LO;
            end
            S_OUT_RD:   n_state = S_OUT_LD;
            S_OUT_LD: begin
                if (w_can_load) n_state = (r_r == r_k - KW'(1)) ? S_IDLE : S_OUT_RD;
            end
            S_ERR:      if (w_can_load) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_k    <= w_k;
                r_s    <= i_in.span;
                r_t    <= i_in.param_t;
                r_d    <= KW'(1);
                r_r    <= KW'(1);
                r_side <= 1'b0;
                r_acc  <= '0;
            end
            S_RD_HI: begin
                r_lo <= w_kdata;
                r_b  <= w_bdata;
            end
            S_RD_WAIT: begin
                r_num <= r_side ? (w_hi_ext - (KNOT_W+1)'(r_t))
                                : ((KNOT_W+1)'(r_t) - (KNOT_W+1)'(r_lo));
                r_den <= w_hi_ext - (KNOT_W+1)'(r_lo);
            end
            S_MUL: r_prod <= $signed({1'b0, r_b}) * r_num;
            S_DIV_WAIT: if (w_ddone) r_acc <= r_acc + SW'(w_quot);
            S_NEXT: if (!r_side && r_r < r_d) r_side <= 1'b1;
            S_WR_B: begin
                r_acc <= '0;
                if (r_r == '0) begin
                    if (r_d == r_k - KW'(1)) begin
                        r_side <= 1'b1;
                    end else begin
                        r_d    <= r_d + KW'(1);
                        r_r    <= r_d + KW'(1);
                        r_side <= 1'b0;
                    end
                end else begin
                    r_r    <= r_r - KW'(1);
                    r_side <= (r_r == KW'(1));
                end
            end
            S_OUT_LD: begin
                if (w_can_load) begin
                    r_val  <= w_bdata;
                    r_idx  <= IDX_W'(7'(r_s) - 7'(r_k) + 7'd1 + 7'(r_r));
                    r_last <= (r_r == r_k - KW'(1));
                    r_stat <= 1'b0;
                    r_r    <= r_r + KW'(1);
                end
            end
            S_ERR: begin
                if (w_can_load) begin
                    r_val  <= '0;
                    r_idx  <= '0;
                    r_last <= 1'b1;
                    r_stat <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_out.valid       = r_ov;
    assign o_out.basis_value = r_val;
    assign o_out.basis_index = r_idx;
    assign o_out.last        = r_last;
    assign o_out.status      = r_stat;
endmodule

>>> rtl/bsbe_ram.sv
`timescale 1ns / 1ps
module bsbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/bsbe_div.sv
`timescale 1ns / 1ps
module bsbe_div #(
    parameter int PW = 51
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [PW-1:0] i_dividend,
    input  logic [31:0]          i_divisor,
    output logic                 o_done,
    output logic signed [PW-1:0] o_quotient
);
    localparam int CW = $clog2(PW + 1);

    logic [PW-1:0] r_q;
    logic [31:0]   r_rem;
    logic [31:0]   r_dvs;
    logic          r_neg;
    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [32:0]   w_sh;
    logic          w_ge;

    assign w_sh = {r_rem, r_q[PW-1]};
    assign w_ge = (w_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(PW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[PW-1];
            r_q   <= i_dividend[PW-1] ? PW'(-i_dividend) : PW'(i_dividend);
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? 32'(w_sh - {1'b0, r_dvs}) : w_sh[31:0];
            r_q   <= {r_q[PW-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule

>>> rtl/bsbe_chk.sv
`timescale 1ns / 1ps
module bsbe_chk #(
    parameter int FRAC_BITS = bsbe_pkg::FRAC_BITS_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [FRAC_BITS:0] i_value,
    input logic [5:0]         i_index,
    input logic               i_last,
    input logic               i_status
);
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_value))
        else $error("result dropped while stalled");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_value <= ONE)
        else $error("basis value above one");

    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status |-> i_last && i_value == '0 && i_index == '0)
        else $error("malformed error result");

    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_out_valid |-> i_last)
        else $error("input taken while an evaluation is still emitting");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
endmodule

bind bspline_basis_eval bsbe_chk #(.FRAC_BITS(FRAC_BITS)) u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_value     (o_out.basis_value),
    .i_index     (o_out.basis_index),
    .i_last      (o_out.last),
    .i_status    (o_out.status)
);
